FILE: sv/rdx_pkg.sv
package rdx_pkg;

    // request codes
    localparam logic [1:0] REQ_CONVERT = 2'd0;
    localparam logic [1:0] REQ_LIN_WR  = 2'd1;
    localparam logic [1:0] REQ_GAM_WR  = 2'd2;

    localparam int CODE_W  = 16;
    localparam int INDEX_W = 16;
    localparam int VALUE_W = 21;
    localparam int CFG_W   = 5;
    localparam int RESET_PRECISION = 12;

    // Rec.709 (D65) to XYZ matrix, units of 1e-7, row major
    localparam longint unsigned MATRIX_E7 [9] = '{
        64'd4124564, 64'd3575761, 64'd1804375,
        64'd2126729, 64'd7151522, 64'd721750,
        64'd193339,  64'd1191920, 64'd9503041
    };

    // DCI companding 48/52.37 folded with the 1e-7 matrix scale
    localparam longint unsigned DCI_NUM = 64'd4800;
    localparam longint unsigned DCI_DEN = 64'd52370000000;

    // Elaboration only: coefficient k in unsigned Q0.frac, round half up
    function automatic longint unsigned dci_coeff(int k, int frac);
        longint unsigned num;
        num = (MATRIX_E7[k] * DCI_NUM) << frac;
        return (num + DCI_DEN / 2) / DCI_DEN;
    endfunction

    // Control that rides along the pipeline next to the datapath
    typedef struct packed {
        logic               valid;
        logic               convert;
        logic               gam_wr;
        logic               last;
        logic [INDEX_W-1:0] idx;
        logic [CODE_W-1:0]  gval;
    } t_ctrl;

endpackage

FILE: sv/rgb_to_dci_xyz_pixel_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_req_type, i_red/green/blue_code, i_table_index,
//                                         i_table_value, i_last_pixel
// output    out        o_valid / i_stall  o_x_code, o_y_code, o_z_code, o_last_result
// config    in         i_cfg_wr_en        i_cfg_wr_data (sample precision)
//
// One item per clock while o_stall is low. Six register stages (linear read, products, row
// sums, rounding, gamma read, output); the first loads at the transfer edge.
// Lookup tables are replicated per component so each memory port sees one read a cycle.
// Tables come up unknown after reset and must be loaded before pixels use them.
// Stall is absorbed by a one-entry skid behind the output register; o_stall is registered.
module rgb_to_dci_xyz_pixel_unit #(
    parameter int MAX_PRECISION        = 12,
    parameter int LINEAR_FRACTION_BITS = 20,
    parameter int COEFF_FRACTION_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rdx_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [rdx_pkg::CODE_W-1:0]   i_red_code,
    input  logic [rdx_pkg::CODE_W-1:0]   i_green_code,
    input  logic [rdx_pkg::CODE_W-1:0]   i_blue_code,
    input  logic [rdx_pkg::INDEX_W-1:0]  i_table_index,
    input  logic [rdx_pkg::VALUE_W-1:0]  i_table_value,
    input  logic                         i_last_pixel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rdx_pkg::CODE_W-1:0]   o_x_code,
    output logic [rdx_pkg::CODE_W-1:0]   o_y_code,
    output logic [rdx_pkg::CODE_W-1:0]   o_z_code,
    output logic                         o_last_result
);
    import rdx_pkg::*;

    localparam int PW  = $clog2(MAX_PRECISION + 1);
    localparam int LIN_W = LINEAR_FRACTION_BITS + 1;
    localparam int RST_PREC = (RESET_PRECISION > MAX_PRECISION) ? MAX_PRECISION
                                                                : RESET_PRECISION;

    // configuration, kept as effective precision and max code
    logic [PW-1:0]            r_prec;
    logic [MAX_PRECISION-1:0] r_max_code;
    logic [CFG_W-1:0]         n_prec_raw;
    logic [PW-1:0]            n_prec;

    always_comb begin
        n_prec_raw = i_cfg_wr_data;
        if (n_prec_raw == '0) begin
            n_prec_raw = CFG_W'(1);
        end
        if (n_prec_raw > CFG_W'(MAX_PRECISION)) begin
            n_prec_raw = CFG_W'(MAX_PRECISION);
        end
        n_prec = PW'(n_prec_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec     <= PW'(RST_PREC);
            r_max_code <= MAX_PRECISION'((32'd1 << RST_PREC) - 32'd1);
        end else if (i_cfg_wr_en) begin
            r_prec     <= n_prec;
            r_max_code <= MAX_PRECISION'((32'd1 << n_prec) - 32'd1);
        end
    end

    // pipeline control
    logic                  r_skid_valid;
    logic                  en;
    logic                  accept;
    logic                  lin_wr;
    t_ctrl                 c0;
    t_ctrl                 c1;
    t_ctrl                 c4;
    t_ctrl                 c5;
    logic [CODE_W-1:0]     codes [3];
    logic [LIN_W-1:0]      lin [3];
    logic [MAX_PRECISION-1:0] q [3];
    logic [CODE_W-1:0]     gcode [3];

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && en;
    assign lin_wr  = accept && (i_req_type == REQ_LIN_WR);

    always_comb begin
        c0         = '0;
        c0.convert = (i_req_type == REQ_CONVERT);
        c0.gam_wr  = (i_req_type == REQ_GAM_WR);
        c0.valid   = accept && (c0.convert || c0.gam_wr);
        c0.last    = i_last_pixel;
        c0.idx     = i_table_index;
        c0.gval    = i_table_value[CODE_W-1:0];
    end

    assign codes[0] = i_red_code;
    assign codes[1] = i_green_code;
    assign codes[2] = i_blue_code;

    rdx_lin_lookup #(
        .MAX_PRECISION        (MAX_PRECISION),
        .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
    ) u_lin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_ctrl        (c0),
        .i_lin_wr      (lin_wr),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_code        (codes),
        .i_max_code    (r_max_code),
        .o_ctrl        (c1),
        .o_lin         (lin)
    );

    rdx_matrix #(
        .MAX_PRECISION        (MAX_PRECISION),
        .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS),
        .COEFF_FRACTION_BITS  (COEFF_FRACTION_BITS)
    ) u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctrl     (c1),
        .i_lin      (lin),
        .i_prec     (r_prec),
        .i_max_code (r_max_code),
        .o_ctrl     (c4),
        .o_q        (q)
    );

    rdx_gamma_lookup #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctrl  (c4),
        .i_q     (q),
        .o_ctrl  (c5),
        .o_code  (gcode)
    );

    // output register plus one-entry skid
    logic              pipe_out;
    logic              take;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_x;
    logic [CODE_W-1:0] r_out_y;
    logic [CODE_W-1:0] r_out_z;
    logic              r_out_last;
    logic [CODE_W-1:0] r_skid_x;
    logic [CODE_W-1:0] r_skid_y;
    logic [CODE_W-1:0] r_skid_z;
    logic              r_skid_last;

    assign pipe_out = en && c5.valid && c5.convert;
    assign take     = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= pipe_out;
            end
        end else if (pipe_out) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_x    <= r_skid_x;
                r_out_y    <= r_skid_y;
                r_out_z    <= r_skid_z;
                r_out_last <= r_skid_last;
            end else if (pipe_out) begin
                r_out_x    <= gcode[0];
                r_out_y    <= gcode[1];
                r_out_z    <= gcode[2];
                r_out_last <= c5.last;
            end
        end else if (pipe_out) begin
            r_skid_x    <= gcode[0];
            r_skid_y    <= gcode[1];
            r_skid_z    <= gcode[2];
            r_skid_last <= c5.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_x_code      = r_out_x;
    assign o_y_code      = r_out_y;
    assign o_z_code      = r_out_z;
    assign o_last_result = r_out_last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall && pipe_out))
        else $error("skid filled without a stalled output");

    a_skid_drain_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_skid_valid) |-> $past(take) && r_out_valid)
        else $error("skid drained without an output transfer");

endmodule

FILE: sv/rdx_lin_lookup.sv
module rdx_lin_lookup #(
    parameter int MAX_PRECISION        = 12,
    parameter int LINEAR_FRACTION_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  rdx_pkg::t_ctrl                i_ctrl,
    input  logic                          i_lin_wr,
    input  logic [rdx_pkg::INDEX_W-1:0]   i_table_index,
    input  logic [rdx_pkg::VALUE_W-1:0]   i_table_value,
    input  logic [rdx_pkg::CODE_W-1:0]    i_code [3],
    input  logic [MAX_PRECISION-1:0]      i_max_code,
    output rdx_pkg::t_ctrl                o_ctrl,
    output logic [LINEAR_FRACTION_BITS:0] o_lin [3]
);
    import rdx_pkg::*;

    localparam int DEPTH = 1 << MAX_PRECISION;
    localparam int LIN_W = LINEAR_FRACTION_BITS + 1;
    localparam int EXT_W = LIN_W + VALUE_W;

    logic                     wr_in_range;
    logic [MAX_PRECISION-1:0] wr_addr;
    logic [EXT_W-1:0]         wr_ext;
    logic [LIN_W-1:0]         wr_val;
    t_ctrl                    r_ctrl;

    assign wr_in_range = (32'(i_table_index) >> MAX_PRECISION) == 32'd0;
    assign wr_addr     = i_table_index[MAX_PRECISION-1:0];
    assign wr_ext      = EXT_W'(i_table_value);
    assign wr_val      = wr_ext[LIN_W-1:0];

    // one table copy per component so all three read in the same cycle
    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [CODE_W-1:0]        clamped;
        logic [MAX_PRECISION-1:0] rd_addr;
        logic [LIN_W-1:0]         r_mem [DEPTH];
        logic [LIN_W-1:0]         r_rd;

        assign clamped = (i_code[g] > CODE_W'(i_max_code)) ? CODE_W'(i_max_code) : i_code[g];
        assign rd_addr = clamped[MAX_PRECISION-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_lin_wr && wr_in_range) begin
                    r_mem[wr_addr] <= wr_val;
                end
                r_rd <= r_mem[rd_addr];
            end
        end

        assign o_lin[g] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    assign o_ctrl = r_ctrl;

endmodule

FILE: sv/rdx_matrix.sv
module rdx_matrix #(
    parameter int MAX_PRECISION        = 12,
    parameter int LINEAR_FRACTION_BITS = 20,
    parameter int COEFF_FRACTION_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  rdx_pkg::t_ctrl                       i_ctrl,
    input  logic [LINEAR_FRACTION_BITS:0]        i_lin [3],
    input  logic [$clog2(MAX_PRECISION+1)-1:0]   i_prec,
    input  logic [MAX_PRECISION-1:0]             i_max_code,
    output rdx_pkg::t_ctrl                       o_ctrl,
    output logic [MAX_PRECISION-1:0]             o_q [3]
);
    import rdx_pkg::*;

    localparam int LIN_W   = LINEAR_FRACTION_BITS + 1;
    localparam int COEFF_W = COEFF_FRACTION_BITS;
    localparam int PROD_W  = COEFF_W + LIN_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC    = COEFF_FRACTION_BITS + LINEAR_FRACTION_BITS;
    localparam int T_W     = ACC_W + MAX_PRECISION + 1;
    localparam int Q_W     = T_W - FRAC;

    localparam logic [COEFF_W-1:0] COEFF [9] = '{
        COEFF_W'(dci_coeff(0, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(1, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(2, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(3, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(4, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(5, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(6, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(7, COEFF_FRACTION_BITS)),
        COEFF_W'(dci_coeff(8, COEFF_FRACTION_BITS))
    };
    localparam logic [T_W-1:0] HALF = T_W'(1) << (FRAC - 1);

    logic [PROD_W-1:0] r_prod [9];
    logic [ACC_W-1:0]  r_acc [3];
    logic [T_W-1:0]    r_t [3];
    t_ctrl             r_ctrl_p;
    t_ctrl             r_ctrl_a;
    t_ctrl             r_ctrl_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r*3+c] <= PROD_W'(COEFF[r*3+c]) * PROD_W'(i_lin[c]);
                end
                r_acc[r] <= ACC_W'(r_prod[r*3]) + ACC_W'(r_prod[r*3+1])
                          + ACC_W'(r_prod[r*3+2]);
                // acc * (2^p - 1) + half, as shift and subtract
                r_t[r] <= (T_W'(r_acc[r]) << i_prec) - T_W'(r_acc[r]) + HALF;
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_quant
        logic [Q_W-1:0] q_full;
        assign q_full = r_t[g][T_W-1:FRAC];
        assign o_q[g] = (q_full > Q_W'(i_max_code)) ? i_max_code
                                                    : q_full[MAX_PRECISION-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_p <= '0;
            r_ctrl_a <= '0;
            r_ctrl_t <= '0;
        end else if (i_en) begin
            r_ctrl_p <= i_ctrl;
            r_ctrl_a <= r_ctrl_p;
            r_ctrl_t <= r_ctrl_a;
        end
    end

    assign o_ctrl = r_ctrl_t;

endmodule

FILE: sv/rdx_gamma_lookup.sv
module rdx_gamma_lookup #(
    parameter int MAX_PRECISION = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  rdx_pkg::t_ctrl              i_ctrl,
    input  logic [MAX_PRECISION-1:0]    i_q [3],
    output rdx_pkg::t_ctrl              o_ctrl,
    output logic [rdx_pkg::CODE_W-1:0]  o_code [3]
);
    import rdx_pkg::*;

    localparam int DEPTH = 1 << MAX_PRECISION;

    logic                     wr_en;
    logic [MAX_PRECISION-1:0] wr_addr;
    t_ctrl                    r_ctrl;

    // table writes travel down the pipe so they land in order with reads
    assign wr_en   = i_ctrl.valid && i_ctrl.gam_wr
                     && ((32'(i_ctrl.idx) >> MAX_PRECISION) == 32'd0);
    assign wr_addr = i_ctrl.idx[MAX_PRECISION-1:0];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [CODE_W-1:0] r_mem [DEPTH];
        logic [CODE_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (wr_en) begin
                    r_mem[wr_addr] <= i_ctrl.gval;
                end
                r_rd <= r_mem[i_q[g]];
            end
        end

        assign o_code[g] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    assign o_ctrl = r_ctrl;

endmodule
